>>> rtl/eaot_pkg.sv
// shared types, constants and helpers for the edge/action outcome table
`default_nettype none
package eaot_pkg;

  localparam int MAP_BYTES   = 65536;
  localparam int EDGE_SLOTS  = 4096;
  localparam int ACTIONS     = 47;
  localparam int COUNT_BITS  = 32;

  localparam int TABLE_DEPTH = EDGE_SLOTS * ACTIONS;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SLOT_W      = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;

  localparam logic       FUNC_BITMAP = 1'b0;
  localparam logic       FUNC_ACTION = 1'b1;
  localparam logic [7:0] VIRGIN_MARK = 8'hFF;

  typedef struct packed {
    logic       func;
    logic [7:0] trace_byte;
    logic [7:0] virgin_byte;
    logic       last_byte;
    logic [5:0] action;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  action_index;
    logic [31:0] enabled_count;
    logic [31:0] disabled_count;
    logic [16:0] coverage;
    logic [16:0] cov_gain;
    logic [15:0] edge_id;
    logic        last_of_run;
  } out_item_t;

  // scan summary including the byte being accepted
  typedef struct packed {
    logic [16:0] cov;
    logic [15:0] edge_pos;
  } scan_res_t;

  typedef logic [COUNT_BITS-1:0] count_t;

  // edges beyond the slot range fall back to slot 0
  function automatic logic [SLOT_W-1:0] slot_of(input logic [15:0] e);
    logic [SLOT_W-1:0] s;
    s = ({1'b0, e} < 17'(EDGE_SLOTS)) ? e[SLOT_W-1:0] : '0;
    return s;
  endfunction

  function automatic logic [5:0] map_action(input logic [5:0] a);
    logic [5:0] m;
    m = ({1'b0, a} >= 7'(ACTIONS)) ? 6'(ACTIONS - 1) : a;
    return m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/edge_action_outcome_table_core.sv
// top level of the edge/action outcome table: sequencer, tables and result register
//
// usage
//   input channel (in_valid / in_stall / in_data): bitmap transactions carry one
//   (trace byte, virgin byte) pair each and are taken one per cycle while the
//   block is idle; action transactions record the policy's choice when taken.
//   a bitmap transaction with last_byte set ends the scan: the block credits the
//   previously recorded (edge, action) pair, then emits one result transaction per
//   action on out_valid / out_stall / out_data, the last one with last_of_run set.
// sequence
//   with a pair to credit, the credited entry is read and written back incremented
//   before the readout; each result then goes through the single read port of
//   the tables (address, registered read, load of the result register).
//   in_stall stays high from the last byte until the final result is taken.
// reset
//   after rst_n the block sweeps both tables to zero, one entry per cycle, all
//   EDGE_SLOTS * ACTIONS entries (192512 by default), with in_stall high.
// backpressure
//   out_stall simply holds the result register; the sequencer waits on it.
`default_nettype none
module edge_action_outcome_table_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire eaot_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output eaot_pkg::out_item_t       out_data
);
  import eaot_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_CLEAR = 3'd0;  // zero sweep after reset
  localparam logic [2:0] S_IDLE  = 3'd1;  // taking transactions
  localparam logic [2:0] S_CRD   = 3'd2;  // read the credited entry
  localparam logic [2:0] S_CWR   = 3'd3;  // write it back incremented
  localparam logic [2:0] S_RADDR = 3'd4;  // form readout address
  localparam logic [2:0] S_RRD   = 3'd5;  // read one action's counters
  localparam logic [2:0] S_RLD   = 3'd6;  // load the result register
  localparam logic [2:0] S_ROUT  = 3'd7;  // wait for the result to be taken

  logic [2:0] state_r, state_nxt;

  // input side decode
  logic in_acc, byte_en, last_acc, act_acc;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign byte_en  = in_acc && (in_data.func == FUNC_BITMAP);
  assign last_acc = byte_en && in_data.last_byte;
  assign act_acc  = in_acc && (in_data.func == FUNC_ACTION);

  scan_res_t scan_res;

  eaot_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (byte_en),
    .last        (in_data.last_byte),
    .trace_byte  (in_data.trace_byte),
    .virgin_byte (in_data.virgin_byte),
    .res         (scan_res)
  );

  // feedback state
  logic [16:0]       prev_cov_r;
  logic [16:0]       pend_cov_r;
  logic [SLOT_W-1:0] pend_edge_r;
  logic [SLOT_W-1:0] cred_edge_r;
  logic [5:0]        cred_act_r;
  logic              cred_valid_r;

  // current run, captured on the last byte
  logic [16:0]       run_cov_r;
  logic [16:0]       run_fresh_r;
  logic              run_grew_r;
  logic [SLOT_W-1:0] run_slot_r;

  logic              grew;
  logic [SLOT_W-1:0] scan_slot;
  assign grew      = scan_res.cov > prev_cov_r;
  assign scan_slot = slot_of(scan_res.edge_pos);

  logic [5:0]        act_cnt_r;
  logic              act_last;
  assign act_last = (act_cnt_r == 6'(ACTIONS - 1));

  logic [ADDR_W-1:0] clr_cnt_r;
  logic              clr_done;
  assign clr_done = (clr_cnt_r == ADDR_W'(TABLE_DEPTH - 1));

  // shared index unit: credited pair while idle and through the credit read,
  // so the write-back lands on the same entry; readout entry otherwise
  logic              idx_cred;
  logic [SLOT_W-1:0] idx_slot;
  logic [5:0]        idx_act;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] addr_r;

  assign idx_cred = (state_r == S_IDLE) || (state_r == S_CRD);
  assign idx_slot = idx_cred ? cred_edge_r : run_slot_r;
  assign idx_act  = idx_cred ? cred_act_r  : act_cnt_r;

  eaot_idx u_idx (
    .slot (idx_slot),
    .act  (idx_act),
    .idx  (idx)
  );

  // tables
  logic              clearing;
  logic              grow_we, stall_we;
  logic [ADDR_W-1:0] waddr;
  count_t            grow_rd, stall_rd, grow_wd, stall_wd;

  assign clearing = (state_r == S_CLEAR);
  assign grow_we  = clearing || ((state_r == S_CWR) && run_grew_r);
  assign stall_we = clearing || ((state_r == S_CWR) && !run_grew_r);
  assign waddr    = clearing ? clr_cnt_r : addr_r;
  // counters wrap at their width
  assign grow_wd  = clearing ? '0 : grow_rd + count_t'(1);
  assign stall_wd = clearing ? '0 : stall_rd + count_t'(1);

  eaot_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_grow_ram (
    .clk   (clk),
    .we    (grow_we),
    .waddr (waddr),
    .wdata (grow_wd),
    .raddr (addr_r),
    .rdata (grow_rd)
  );

  eaot_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_DEPTH)) u_stall_ram (
    .clk   (clk),
    .we    (stall_we),
    .waddr (waddr),
    .wdata (stall_wd),
    .raddr (addr_r),
    .rdata (stall_rd)
  );

  // result register
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_acc;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_acc   = out_valid_r && !out_stall;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (last_acc) state_nxt = cred_valid_r ? S_CRD : S_RADDR;
      end
      S_CRD:   state_nxt = S_CWR;
      S_CWR:   state_nxt = S_RRD;   // readout address formed here as well
      S_RADDR: state_nxt = S_RRD;
      S_RRD:   state_nxt = S_RLD;
      S_RLD:   state_nxt = S_ROUT;
      S_ROUT: begin
        if (out_acc) state_nxt = out_data_r.last_of_run ? S_IDLE : S_RRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      act_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      prev_cov_r   <= '0;
      pend_cov_r   <= '0;
      pend_edge_r  <= '0;
      cred_edge_r  <= '0;
      cred_act_r   <= '0;
      cred_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (last_acc) begin
        act_cnt_r  <= '0;
        pend_cov_r <= scan_res.cov;
        pend_edge_r <= scan_slot;
      end else if (state_r == S_RLD && !act_last) begin
        act_cnt_r <= act_cnt_r + 6'd1;
      end
      if (act_acc) begin
        cred_edge_r  <= pend_edge_r;
        cred_act_r   <= map_action(in_data.action);
        cred_valid_r <= 1'b1;
        prev_cov_r   <= pend_cov_r;
      end
      if (state_r == S_RLD) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r <= idx;
    if (last_acc) begin
      run_cov_r   <= scan_res.cov;
      run_fresh_r <= grew ? (scan_res.cov - prev_cov_r) : '0;
      run_grew_r  <= grew;
      run_slot_r  <= scan_slot;
    end
    if (state_r == S_RLD) begin
      out_data_r.action_index   <= act_cnt_r;
      out_data_r.enabled_count  <= 32'(grow_rd);
      out_data_r.disabled_count <= 32'(stall_rd);
      out_data_r.coverage       <= run_cov_r;
      out_data_r.cov_gain       <= run_fresh_r;
      out_data_r.edge_id        <= 16'(run_slot_r);
      out_data_r.last_of_run    <= act_last;
    end
  end

`ifndef NO_ASSERTIONS
  // no results while the tables are being swept
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result presented during table sweep");

  // input is held off whenever a result is pending
  a_stall_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall)
    else $error("input taken while a result is pending");

  // after the final result of a run the channel goes quiet
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data_r.last_of_run) |=> (!out_valid_r && state_r == S_IDLE))
    else $error("run did not end after final result");

  // action counter stays inside the table row
  a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, act_cnt_r} < 7'(ACTIONS)))
    else $error("action counter out of range");

  // tables only written by the sweep or the credit step, one table per credit
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    (grow_we || stall_we) |-> (clearing || (state_r == S_CWR && (grow_we != stall_we))))
    else $error("unexpected table write");
`endif

endmodule
`default_nettype wire

>>> rtl/eaot_ram.sv
// generic single write port ram with registered read
`default_nettype none
module eaot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/eaot_scan.sv
// per-byte coverage count and current edge tracking
`default_nettype none
module eaot_scan (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 byte_en,
  input  wire logic                 last,
  input  wire logic [7:0]           trace_byte,
  input  wire logic [7:0]           virgin_byte,
  output eaot_pkg::scan_res_t       res
);
  import eaot_pkg::*;

  logic [16:0] pos_r, pos_nxt;
  logic [16:0] cov_r, cov_nxt;
  logic [15:0] newest_r, newest_nxt;
  logic        found_r, found_nxt;
  logic [7:0]  hot_val_r, hot_val_nxt;
  logic [15:0] hot_edge_r, hot_edge_nxt;

  always_comb begin
    pos_nxt      = pos_r;
    cov_nxt      = cov_r;
    newest_nxt   = newest_r;
    found_nxt    = found_r;
    hot_val_nxt  = hot_val_r;
    hot_edge_nxt = hot_edge_r;
    if (pos_r < 17'(MAP_BYTES)) begin
      if (virgin_byte != VIRGIN_MARK) begin
        cov_nxt = cov_r + 17'd1;
      end
      if (pos_r != '0) begin
        if (trace_byte != 8'd0 && virgin_byte == VIRGIN_MARK) begin
          newest_nxt = pos_r[15:0];
          found_nxt  = 1'b1;
        end
        if (trace_byte > hot_val_r) begin
          hot_val_nxt  = trace_byte;
          hot_edge_nxt = pos_r[15:0];
        end
      end
      pos_nxt = pos_r + 17'd1;
    end
  end

  assign res.cov      = cov_nxt;
  assign res.edge_pos = found_nxt ? newest_nxt : hot_edge_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_en && last)) begin
      pos_r      <= '0;
      cov_r      <= '0;
      newest_r   <= '0;
      found_r    <= 1'b0;
      hot_val_r  <= '0;
      hot_edge_r <= '0;
    end else if (byte_en) begin
      pos_r      <= pos_nxt;
      cov_r      <= cov_nxt;
      newest_r   <= newest_nxt;
      found_r    <= found_nxt;
      hot_val_r  <= hot_val_nxt;
      hot_edge_r <= hot_edge_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/eaot_idx.sv
// table index unit: slot times action count plus action
`default_nettype none
module eaot_idx (
  input  wire logic [eaot_pkg::SLOT_W-1:0] slot,
  input  wire logic [5:0]                  act,
  output logic      [eaot_pkg::ADDR_W-1:0] idx
);
  import eaot_pkg::*;

  assign idx = ADDR_W'(slot) * ADDR_W'(ACTIONS) + ADDR_W'(act);

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// self-checking testbench for the edge/action outcome table core
import eaot_pkg::*;

class outcome_scoreboard;
  // scan in progress
  logic [16:0] scan_pos;
  logic [16:0] cov_count;
  logic [15:0] newest_pos;
  logic        newest_seen;
  logic [7:0]  hottest_val;
  logic [15:0] hottest_pos;
  // last finished scan and the recorded pair
  logic [16:0] prev_cov;
  logic [16:0] pend_cov;
  logic [15:0] pend_slot;
  logic [15:0] owed_slot;
  logic [5:0]  owed_action;
  logic        owed_valid;
  bit [COUNT_BITS-1:0] growth_cnt [TABLE_DEPTH];
  bit [COUNT_BITS-1:0] stall_cnt [TABLE_DEPTH];
  out_item_t   pending_rows[$];
  int          errors;
  int          n_in;
  int          n_out;
  int          n_scans;

  function new();
    scan_pos    = '0;
    cov_count   = '0;
    newest_pos  = '0;
    newest_seen = 1'b0;
    hottest_val = '0;
    hottest_pos = '0;
    prev_cov    = '0;
    pend_cov    = '0;
    pend_slot   = '0;
    owed_slot   = '0;
    owed_action = '0;
    owed_valid  = 1'b0;
    errors      = 0;
    n_in        = 0;
    n_out       = 0;
    n_scans     = 0;
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // apply one accepted transaction to the scan or the recorded pair; queue rows at the end of a scan
  function void note_input(in_item_t it);
    logic [15:0] edge_pos;
    logic [15:0] slot;
    logic        grew;
    logic [16:0] fresh;
    int          idx;
    out_item_t   row;
    n_in++;
    if (it.func == FUNC_ACTION) begin
      owed_slot   = pend_slot;
      owed_action = (it.action >= ACTIONS) ? 6'(ACTIONS - 1) : it.action;
      owed_valid  = 1'b1;
      prev_cov    = pend_cov;
      return;
    end
    if (scan_pos < MAP_BYTES) begin
      if (it.virgin_byte != VIRGIN_MARK) cov_count++;
      if (scan_pos >= 1) begin
        if (it.trace_byte != 0 && it.virgin_byte == VIRGIN_MARK) begin
          newest_pos  = scan_pos[15:0];
          newest_seen = 1'b1;
        end
        if (it.trace_byte > hottest_val) begin
          hottest_val = it.trace_byte;
          hottest_pos = scan_pos[15:0];
        end
      end
      scan_pos++;
    end
    if (!it.last_byte) return;

    edge_pos = newest_seen ? newest_pos : hottest_pos;
    slot     = (edge_pos < EDGE_SLOTS) ? edge_pos : 16'd0;
    grew     = cov_count > prev_cov;
    fresh    = grew ? cov_count - prev_cov : 17'd0;
    if (owed_valid) begin
      idx = int'(owed_slot) * ACTIONS + int'(owed_action);
      if (grew) growth_cnt[idx] = growth_cnt[idx] + 1'b1;
      else stall_cnt[idx] = stall_cnt[idx] + 1'b1;
    end
    for (int a = 0; a < ACTIONS; a++) begin
      idx                = int'(slot) * ACTIONS + a;
      row.action_index   = 6'(a);
      row.enabled_count  = growth_cnt[idx];
      row.disabled_count = stall_cnt[idx];
      row.coverage       = cov_count;
      row.cov_gain       = fresh;
      row.edge_id        = slot;
      row.last_of_run    = (a == ACTIONS - 1);
      pending_rows.push_back(row);
    end
    pend_cov    = cov_count;
    pend_slot   = slot;
    scan_pos    = '0;
    cov_count   = '0;
    newest_pos  = '0;
    newest_seen = 1'b0;
    hottest_val = '0;
    hottest_pos = '0;
    n_scans++;
  endfunction

  task compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
    if (got_v !== want_v)
      report($sformatf("result %0d %s got %0h want %0h", n_out, name, got_v, want_v));
  endtask

  task check_result(out_item_t got);
    out_item_t want;
    if (pending_rows.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected", n_out));
      n_out++;
      return;
    end
    want = pending_rows.pop_front();
    compare_field("action_index", 32'(got.action_index), 32'(want.action_index));
    compare_field("enabled_count", got.enabled_count, want.enabled_count);
    compare_field("disabled_count", got.disabled_count, want.disabled_count);
    compare_field("coverage", 32'(got.coverage), 32'(want.coverage));
    compare_field("cov_gain", 32'(got.cov_gain), 32'(want.cov_gain));
    compare_field("edge_id", 32'(got.edge_id), 32'(want.edge_id));
    compare_field("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
    n_out++;
  endtask
endclass

module tb;
  // the reset sweep dominates, then 47 slow results per scan
  localparam int LIMIT       = 1500000;
  localparam int LONG_HOLD   = 400;
  localparam int RANDOM_ITEMS = 120;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  outcome_scoreboard sb = new();

  // handshake control shared by the driver, the receiver and the stimulus
  bit tx_calm   = 1'b0;   // sender offers back to back
  bit rx_calm   = 1'b0;   // receiver never stalls
  bit hold_long = 1'b0;   // request for one long receiver hold-off
  int cycle_count = 0;

  edge_action_outcome_table_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake or missing result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // bitmap transaction; the action field is noise the block must ignore
  function automatic in_item_t byte_item(logic [7:0] tr, logic [7:0] vg, logic lst);
    in_item_t it;
    it.func        = FUNC_BITMAP;
    it.trace_byte  = tr;
    it.virgin_byte = vg;
    it.last_byte   = lst;
    it.action      = 6'($urandom_range(0, 63));
    return it;
  endfunction

  // action transaction; the bitmap fields are noise
  function automatic in_item_t action_item(logic [5:0] act);
    in_item_t it;
    it.func        = FUNC_ACTION;
    it.trace_byte  = 8'($urandom_range(0, 255));
    it.virgin_byte = 8'($urandom_range(0, 255));
    it.last_byte   = 1'($urandom_range(0, 1));
    it.action      = act;
    return it;
  endfunction

  // entered and left just after a falling edge; valid stays up across back to back items
  task send_item(in_item_t it);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task wait_results();
    while (sb.pending_rows.size() != 0) @(posedge clk);
  endtask

  // random scan of a few bytes, optionally with an action transaction before one of its bytes
  task random_scan(bit with_noise);
    int len;
    int cut;
    logic [7:0] tr;
    logic [7:0] vg;
    len = $urandom_range(1, 8);
    cut = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      if (with_noise && i == cut) send_item(action_item(6'($urandom_range(0, 63))));
      tr = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      vg = ($urandom_range(0, 1) == 0) ? VIRGIN_MARK : 8'($urandom_range(0, 255));
      send_item(byte_item(tr, vg, i == len - 1));
    end
  endtask

  // result side: random stall before each result, calm stretches, one long hold-off
  initial begin : receiver
    int n;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_long) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_long = 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        n = rx_calm ? 0 : $urandom_range(0, 7);
        if (n > 0) begin
          out_stall = 1'b1;
          repeat (n) @(negedge clk);
        end
      end
      out_stall = 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int base;
    int s;
    int kind;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: first scan has no recorded pair, so nothing is credited;
    // position 0 never becomes an edge, newest-unseen edge wins
    send_item(byte_item(8'hFF, VIRGIN_MARK, 1'b0));
    send_item(byte_item(8'h00, 8'h00, 1'b0));
    send_item(byte_item(8'h05, VIRGIN_MARK, 1'b1));
    // out-of-range action folds to the top action
    send_item(action_item(6'd63));
    // one-byte scan, no edge at all, coverage stays level -> stall credit
    send_item(byte_item(8'h00, 8'h00, 1'b1));
    send_item(action_item(6'd0));
    // same coverage again -> stall credit
    send_item(byte_item(8'h00, 8'hFE, 1'b1));
    // no action in between: the same pair is credited again;
    // tie on the hottest value keeps the first position
    send_item(byte_item(8'h10, 8'h00, 1'b0));
    send_item(byte_item(8'hC8, 8'h01, 1'b0));
    send_item(byte_item(8'hC8, 8'h80, 1'b1));
    // repeated action transactions overwrite each other
    send_item(action_item(6'd47));
    send_item(action_item(6'd5));
    // all virgin, no hits: edge 0, coverage 0, no growth
    send_item(byte_item(8'h00, VIRGIN_MARK, 1'b0));
    send_item(byte_item(8'h00, VIRGIN_MARK, 1'b0));
    send_item(byte_item(8'h00, VIRGIN_MARK, 1'b1));
    send_item(action_item(6'd46));
    send_item(byte_item(8'h01, 8'h7F, 1'b0));
    send_item(byte_item(8'h01, VIRGIN_MARK, 1'b1));
    send_item(action_item(6'd42));

    // random: mostly scan followed by an action, plus loose actions,
    // scans with no action and actions in the middle of a scan
    base = sb.n_in;
    s = 0;
    while (sb.n_in - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) tx_calm = !tx_calm;
      // receiver holds off while the sender keeps offering the next scan
      if (s == 4) hold_long = 1'b1;
      // sender pauses until the table readout has fully drained
      if (s == 12) wait_results();
      kind = $urandom_range(0, 9);
      if (kind == 8) begin
        send_item(action_item(6'($urandom_range(0, 63))));
      end else begin
        random_scan(kind == 9);
        if (kind < 7) send_item(action_item(6'($urandom_range(0, 63))));
      end
      s++;
    end

    tx_calm = 1'b0;
    send_item(byte_item(8'h03, 8'h00, 1'b1));
    send_item(action_item(6'd1));
    random_scan(1'b0);

    in_valid = 1'b0;
    wait_results();
    repeat (40) @(posedge clk);
    $display("run covered %0d input transactions in %0d scans, %0d results checked",
             sb.n_in, sb.n_scans, sb.n_out);
    $display("included repeated credits, out-of-range actions and a long hold-off, %0d errors",
             sb.errors);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

>>> edge_action_outcome_table_core.f
rtl/eaot_pkg.sv
rtl/eaot_ram.sv
rtl/eaot_scan.sv
rtl/eaot_idx.sv
rtl/edge_action_outcome_table_core.sv
tb/sv/tb.sv
